### hdl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants shared by the pulse beat detector modules.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int SAMPLE_W = 10;
    localparam int GAP_W    = 16;
    localparam int BEATS_W  = 8;
    localparam int PHASE_W  = 4;
    localparam int BPM_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_THR = 2'd1;

    localparam logic [GAP_W-1:0]    RST_MIN_GAP   = 16'd900;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 10'd550;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_MIN = 10'd1000;
    localparam logic [PHASE_W-1:0]  RST_CAL_PHASE = 4'd10;
    localparam logic [PHASE_W-1:0]  WEAK_PHASE    = 4'd5;
    localparam logic [PHASE_W-1:0]  RECAL_PHASE   = 4'd3;
    localparam logic [BEATS_W-1:0]  WEAK_BEATS    = 8'd4;
    localparam logic [SAMPLE_W:0]   THR_OFFSET    = 11'd30;
    localparam logic [GAP_W-1:0]    GAP_MAX       = 16'hFFFF;
    localparam logic [BEATS_W-1:0]  BEATS_MAX     = 8'hFF;
    localparam logic [SAMPLE_W-1:0] THR_MAX       = 10'd1023;

    typedef struct packed {
        logic [1:0]          func;
        logic [SAMPLE_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic                beat;
        logic [GAP_W-1:0]    beat_gap;
        logic                bpm_valid;
        logic [BPM_W-1:0]    bpm;
        logic [SAMPLE_W-1:0] threshold;
    } t_out;

    typedef struct packed {
        logic [GAP_W-1:0]    min_gap_samples;
        logic [SAMPLE_W-1:0] default_threshold;
    } t_cfg;

endpackage

### hdl/pbd_cfg.sv
// ----------------------------------------------------------------------------
// pbd_cfg
// Configuration registers for the minimum beat gap and default threshold.
// ----------------------------------------------------------------------------
module pbd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output pbd_pkg::t_cfg                    o_cfg
);

    pbd_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap_samples   <= pbd_pkg::RST_MIN_GAP;
            r_cfg.default_threshold <= pbd_pkg::RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pbd_pkg::CFG_MIN_GAP) begin
                r_cfg.min_gap_samples <= i_cfg_data[pbd_pkg::GAP_W-1:0];
            end else if (i_cfg_index == pbd_pkg::CFG_DEFAULT_THR) begin
                r_cfg.default_threshold <= i_cfg_data[pbd_pkg::SAMPLE_W-1:0];
            end
        end
    end

endmodule

### hdl/pbd_core.sv
// ----------------------------------------------------------------------------
// pbd_core
// Detector state and the combinational update for one request.
// ----------------------------------------------------------------------------
module pbd_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  pbd_pkg::t_in  i_item,
    input  pbd_pkg::t_cfg i_cfg,
    output pbd_pkg::t_out o_result
);

    localparam int SW   = pbd_pkg::SAMPLE_W;
    localparam int KEEP = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
    localparam logic [SW-1:0] SAMPLE_MASK = SW'((32'd1 << KEEP) - 32'd1);

    logic                          r_pulse_high, n_pulse_high;
    logic [pbd_pkg::GAP_W-1:0]     r_gap_count, n_gap_count;
    logic [pbd_pkg::BEATS_W-1:0]   r_window_beats, n_window_beats;
    logic [pbd_pkg::BEATS_W-1:0]   r_prev_beats, n_prev_beats;
    logic [pbd_pkg::PHASE_W-1:0]   r_cal_phase, n_cal_phase;
    logic [SW-1:0]                 r_level_max, n_level_max;
    logic [SW-1:0]                 r_level_min, n_level_min;
    logic [SW-1:0]                 r_threshold, n_threshold;

    logic [SW-1:0]                 s;
    logic [pbd_pkg::PHASE_W-1:0]   phase_eff;
    logic [pbd_pkg::BEATS_W:0]     beat_sum;
    logic [SW:0]                   level_sum;
    logic [SW:0]                   recal_half;
    logic [SW-1:0]                 recal_thr;

    assign s         = i_item.sample & SAMPLE_MASK;
    assign beat_sum  = {1'b0, r_prev_beats} + {1'b0, r_window_beats};
    assign level_sum = {1'b0, r_level_max} + {1'b0, r_level_min};

    always_comb begin
        recal_half = '0;
        if (level_sum >= pbd_pkg::THR_OFFSET) begin
            recal_half = (level_sum - pbd_pkg::THR_OFFSET) >> 1;
        end
        if (r_level_max == '0 || r_level_min == '0) begin
            recal_thr = i_cfg.default_threshold;
        end else if (recal_half[SW]) begin
            recal_thr = pbd_pkg::THR_MAX;
        end else begin
            recal_thr = recal_half[SW-1:0];
        end
    end

    always_comb begin
        n_pulse_high   = r_pulse_high;
        n_gap_count    = r_gap_count;
        n_window_beats = r_window_beats;
        n_prev_beats   = r_prev_beats;
        n_cal_phase    = r_cal_phase;
        n_level_max    = r_level_max;
        n_level_min    = r_level_min;
        n_threshold    = r_threshold;
        phase_eff      = r_cal_phase;
        o_result       = '0;

        unique case (i_item.func)
            pbd_pkg::FUNC_SAMPLE: begin
                if (s > r_threshold && !r_pulse_high
                        && r_gap_count > i_cfg.min_gap_samples) begin
                    n_pulse_high = 1'b1;
                    if (r_window_beats != pbd_pkg::BEATS_MAX) begin
                        n_window_beats = r_window_beats + 1'b1;
                    end
                    o_result.beat     = 1'b1;
                    o_result.beat_gap = r_gap_count;
                    n_gap_count       = '0;
                end else if (r_pulse_high && s < r_threshold) begin
                    n_pulse_high = 1'b0;
                end else if (!r_pulse_high) begin
                    if (r_gap_count != pbd_pkg::GAP_MAX) begin
                        n_gap_count = r_gap_count + 1'b1;
                    end
                end
                if (r_cal_phase != '0) begin
                    if (s > r_level_max) begin
                        n_level_max = s;
                    end else if (s < r_level_min) begin
                        n_level_min = s;
                    end
                end
            end
            pbd_pkg::FUNC_TICK: begin
                o_result.bpm_valid = 1'b1;
                if (r_prev_beats != '0) begin
                    o_result.bpm = pbd_pkg::BPM_W'({1'b0, beat_sum, 2'b00}
                                                   + {2'b00, beat_sum, 1'b0});
                end else begin
                    o_result.bpm = pbd_pkg::BPM_W'({1'b0, r_window_beats, 3'b000}
                                                   + {2'b00, r_window_beats, 2'b00});
                end
                if (r_window_beats > pbd_pkg::WEAK_BEATS) begin
                    n_prev_beats = r_window_beats;
                end else begin
                    phase_eff    = pbd_pkg::WEAK_PHASE;
                    n_prev_beats = '0;
                end
                n_window_beats = '0;
                if (phase_eff >= pbd_pkg::RECAL_PHASE) begin
                    n_cal_phase = '0;
                    n_threshold = recal_thr;
                    n_level_max = '0;
                end else begin
                    n_cal_phase = phase_eff + 1'b1;
                end
            end
            pbd_pkg::FUNC_START: begin
                n_threshold = i_cfg.default_threshold;
                n_level_min = pbd_pkg::RST_LEVEL_MIN;
                n_cal_phase = pbd_pkg::RST_CAL_PHASE;
            end
            pbd_pkg::FUNC_NOP: begin
            end
        endcase

        o_result.threshold = n_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_high   <= 1'b0;
            r_gap_count    <= '0;
            r_window_beats <= '0;
            r_prev_beats   <= '0;
            r_cal_phase    <= pbd_pkg::RST_CAL_PHASE;
            r_level_max    <= '0;
            r_level_min    <= pbd_pkg::RST_LEVEL_MIN;
            r_threshold    <= pbd_pkg::RST_THRESHOLD;
        end else if (i_en) begin
            r_pulse_high   <= n_pulse_high;
            r_gap_count    <= n_gap_count;
            r_window_beats <= n_window_beats;
            r_prev_beats   <= n_prev_beats;
            r_cal_phase    <= n_cal_phase;
            r_level_max    <= n_level_max;
            r_level_min    <= n_level_min;
            r_threshold    <= n_threshold;
        end
    end

endmodule

### hdl/pulse_beat_detector_bpm.sv
// A result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while no held result is stalled; the
// whole update is one combinational pass from state into the result register.
// Reset is synchronous and active low; it restores the state and the
// configuration registers to their defaults and empties the result register.
// ----------------------------------------------------------------------------
// pulse_beat_detector_bpm
// Pulse-sensor beat detector with a self-calibrating threshold and BPM output.
// ----------------------------------------------------------------------------
module pulse_beat_detector_bpm #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pbd_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pbd_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pbd_pkg::t_cfg cfg;
    pbd_pkg::t_out result;
    logic          accept;
    logic          r_out_valid;
    pbd_pkg::t_out r_out_data;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    pbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pbd_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("Accepted request produced no result.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("Input stalled while the result register is empty.");

    a_beat_excl_bpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.beat) |-> !o_out_data.bpm_valid)
        else $error("Beat and BPM reported in the same result.");

    a_gap_only_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.beat) |-> (o_out_data.beat_gap == '0))
        else $error("Beat gap reported without a beat.");

    a_bpm_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.bpm_valid) |-> (o_out_data.bpm == '0))
        else $error("BPM reported outside a window tick.");
`endif

endmodule

### tb/tb_pulse_beat_detector_bpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_beat_detector_bpm
// Self-checking testbench for the pulse beat detector. A behavioral model of
// the detector inside the bench predicts the result of every accepted request,
// and a checker compares each result with the oldest prediction, field by
// field. Directed tests cover reset defaults, the threshold clamp, beat
// detection and counter saturation. Random pulse trains then run under several
// register settings, with random idling on both channels and a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_beat_detector_bpm;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int LONG_HOLD_CYCLES = 48;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 160;
    localparam int MAX_PRINTED      = 40;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    pbd_pkg::t_in                   i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    pbd_pkg::t_out                  o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pbd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pbd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    logic                         det_pulse_high;
    logic [pbd_pkg::GAP_W-1:0]    det_gap;
    logic [pbd_pkg::BEATS_W-1:0]  det_win_beats;
    logic [pbd_pkg::BEATS_W-1:0]  det_prev_beats;
    logic [pbd_pkg::PHASE_W-1:0]  det_phase;
    logic [pbd_pkg::SAMPLE_W-1:0] det_level_max;
    logic [pbd_pkg::SAMPLE_W-1:0] det_level_min;
    logic [pbd_pkg::SAMPLE_W-1:0] det_thr;
    logic [pbd_pkg::GAP_W-1:0]    cfg_min_gap;
    logic [pbd_pkg::SAMPLE_W-1:0] cfg_default_thr;

    pbd_pkg::t_out expected_results[$];
    int   error_count  = 0;
    int   stuck_cycles = 0;
    bit   idle_on       = 1'b1;
    bit   long_hold_req = 1'b0;

    pulse_beat_detector_bpm #(
        .SAMPLE_BITS(pbd_pkg::SAMPLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic void detector_reset();
        det_pulse_high  = 1'b0;
        det_gap         = '0;
        det_win_beats   = '0;
        det_prev_beats  = '0;
        det_phase       = pbd_pkg::RST_CAL_PHASE;
        det_level_max   = '0;
        det_level_min   = pbd_pkg::RST_LEVEL_MIN;
        det_thr         = pbd_pkg::RST_THRESHOLD;
        cfg_min_gap     = pbd_pkg::RST_MIN_GAP;
        cfg_default_thr = pbd_pkg::RST_THRESHOLD;
    endfunction

    function automatic logic [pbd_pkg::SAMPLE_W-1:0] recalibrated_threshold();
        int t;
        if (det_level_max == '0 || det_level_min == '0) begin
            return cfg_default_thr;
        end
        t = (int'(det_level_max) + int'(det_level_min) - int'(pbd_pkg::THR_OFFSET)) / 2;
        if (t < 0) begin
            t = 0;
        end
        if (t > int'(pbd_pkg::THR_MAX)) begin
            t = int'(pbd_pkg::THR_MAX);
        end
        return t[pbd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic pbd_pkg::t_out detector_step(input pbd_pkg::t_in req);
        pbd_pkg::t_out res;
        int   bpm_calc;
        res = '0;
        case (req.func)
            pbd_pkg::FUNC_SAMPLE: begin
                if (req.sample > det_thr && !det_pulse_high && det_gap > cfg_min_gap) begin
                    det_pulse_high = 1'b1;
                    if (det_win_beats != pbd_pkg::BEATS_MAX) begin
                        det_win_beats++;
                    end
                    res.beat     = 1'b1;
                    res.beat_gap = det_gap;
                    det_gap      = '0;
                end else if (det_pulse_high && req.sample < det_thr) begin
                    det_pulse_high = 1'b0;
                end else if (!det_pulse_high) begin
                    if (det_gap != pbd_pkg::GAP_MAX) begin
                        det_gap++;
                    end
                end
                if (det_phase != '0) begin
                    if (req.sample > det_level_max) begin
                        det_level_max = req.sample;
                    end else if (req.sample < det_level_min) begin
                        det_level_min = req.sample;
                    end
                end
            end
            pbd_pkg::FUNC_TICK: begin
                res.bpm_valid = 1'b1;
                if (det_prev_beats != '0) begin
                    bpm_calc = (int'(det_prev_beats) + int'(det_win_beats)) * 6;
                end else begin
                    bpm_calc = int'(det_win_beats) * 12;
                end
                res.bpm = bpm_calc[pbd_pkg::BPM_W-1:0];
                if (det_win_beats > pbd_pkg::WEAK_BEATS) begin
                    det_prev_beats = det_win_beats;
                end else begin
                    det_phase      = pbd_pkg::WEAK_PHASE;
                    det_prev_beats = '0;
                end
                det_win_beats = '0;
                if (det_phase >= pbd_pkg::RECAL_PHASE) begin
                    det_phase     = '0;
                    det_thr       = recalibrated_threshold();
                    det_level_max = '0;
                end else begin
                    det_phase++;
                end
            end
            pbd_pkg::FUNC_START: begin
                det_thr       = cfg_default_thr;
                det_level_min = pbd_pkg::RST_LEVEL_MIN;
                det_phase     = pbd_pkg::RST_CAL_PHASE;
            end
            default: begin
            end
        endcase
        res.threshold = det_thr;
        return res;
    endfunction

    function automatic pbd_pkg::t_in make_req(input logic [1:0] func,
                                              input logic [pbd_pkg::SAMPLE_W-1:0] s);
        pbd_pkg::t_in req;
        req.func   = func;
        req.sample = s;
        return req;
    endfunction

    function automatic logic [pbd_pkg::SAMPLE_W-1:0] sample_below();
        int v;
        if (det_thr == '0) begin
            return '0;
        end
        v = $urandom_range(0, int'(det_thr) - 1);
        return v[pbd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic [pbd_pkg::SAMPLE_W-1:0] sample_above();
        int v;
        if (det_thr == pbd_pkg::THR_MAX) begin
            return pbd_pkg::THR_MAX;
        end
        v = $urandom_range(int'(det_thr) + 1, int'(pbd_pkg::THR_MAX));
        return v[pbd_pkg::SAMPLE_W-1:0];
    endfunction

    // Mostly pulse-shaped samples placed around the live threshold, with some
    // noise, window ticks, starts and unused kinds mixed in.
    function automatic pbd_pkg::t_in random_request();
        pbd_pkg::t_in req;
        int  pick;
        int  v;
        v          = $urandom_range(0, int'(pbd_pkg::THR_MAX));
        req.sample = v[pbd_pkg::SAMPLE_W-1:0];
        req.func   = pbd_pkg::FUNC_SAMPLE;
        pick       = $urandom_range(0, 99);
        if (pick < 3) begin
            req.func = pbd_pkg::FUNC_TICK;
        end else if (pick == 3) begin
            req.func = pbd_pkg::FUNC_START;
        end else if (pick == 4) begin
            req.func = pbd_pkg::FUNC_NOP;
        end else if (pick < 10) begin
        end else if (det_pulse_high) begin
            req.sample = ($urandom_range(0, 4) < 3) ? sample_below() : sample_above();
        end else if (det_gap > cfg_min_gap) begin
            req.sample = ($urandom_range(0, 9) < 7) ? sample_above() : sample_below();
        end else begin
            req.sample = sample_below();
        end
        return req;
    endfunction

    task automatic send_request(input pbd_pkg::t_in req);
        int gap_len;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap_len = $urandom_range(1, 4);
            repeat (gap_len) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_results.push_back(detector_step(req));
    endtask

    task automatic drain_outputs();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [pbd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [pbd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            pbd_pkg::CFG_MIN_GAP:     cfg_min_gap     = data;
            pbd_pkg::CFG_DEFAULT_THR: cfg_default_thr = data[pbd_pkg::SAMPLE_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, pbd_pkg::THR_MAX));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, '0));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, pbd_pkg::RST_THRESHOLD));
        send_request(make_req(pbd_pkg::FUNC_NOP, 10'd777));
        send_request(make_req(pbd_pkg::FUNC_TICK, '0));
    endtask

    task automatic test_negative_threshold();
        send_request(make_req(pbd_pkg::FUNC_START, '0));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd10));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd5));
        send_request(make_req(pbd_pkg::FUNC_TICK, '0));
        send_request(make_req(pbd_pkg::FUNC_START, '0));
    endtask

    task automatic test_beat_detection();
        drain_outputs();
        write_register(pbd_pkg::CFG_MIN_GAP, '0);
        write_register(pbd_pkg::CFG_DEFAULT_THR, 16'd512);
        send_request(make_req(pbd_pkg::FUNC_START, '0));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd100));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd512));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd513));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, pbd_pkg::THR_MAX));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd512));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd511));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd600));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd600));
        send_request(make_req(pbd_pkg::FUNC_SAMPLE, '0));
        send_request(make_req(pbd_pkg::FUNC_TICK, '0));
        send_request(make_req(pbd_pkg::FUNC_NOP, pbd_pkg::THR_MAX));
    endtask

    task automatic test_output_hold();
        long_hold_req = 1'b1;
        repeat (24) begin
            send_request(random_request());
        end
        drain_outputs();
    endtask

    task automatic test_sender_pause();
        repeat (12) begin
            send_request(random_request());
        end
        drain_outputs();
        repeat (12) begin
            send_request(random_request());
        end
        drain_outputs();
    endtask

    task automatic test_window_saturation();
        drain_outputs();
        write_register(pbd_pkg::CFG_MIN_GAP, '0);
        write_register(pbd_pkg::CFG_DEFAULT_THR, 16'd500);
        send_request(make_req(pbd_pkg::FUNC_START, '0));
        repeat (260) begin
            send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd900));
            send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd100));
            send_request(make_req(pbd_pkg::FUNC_SAMPLE, 10'd100));
        end
        send_request(make_req(pbd_pkg::FUNC_TICK, '0));
        send_request(make_req(pbd_pkg::FUNC_TICK, '0));
    endtask

    task automatic test_random_traffic();
        logic [pbd_pkg::CFG_DATA_W-1:0] gap_word;
        logic [pbd_pkg::CFG_DATA_W-1:0] thr_word;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_outputs();
            gap_word = pbd_pkg::CFG_DATA_W'($urandom_range(0, 12));
            thr_word = pbd_pkg::CFG_DATA_W'($urandom_range(0, 65535));
            case (p)
                0: begin
                    gap_word = '0;
                    thr_word[pbd_pkg::SAMPLE_W-1:0] = '0;
                end
                1: thr_word[pbd_pkg::SAMPLE_W-1:0] = pbd_pkg::THR_MAX;
                2: gap_word = pbd_pkg::GAP_MAX;
                3: gap_word = pbd_pkg::CFG_DATA_W'($urandom_range(0, 3));
                default: begin
                end
            endcase
            if (p == RANDOM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            write_register(pbd_pkg::CFG_MIN_GAP, gap_word);
            write_register(pbd_pkg::CFG_DEFAULT_THR, thr_word);
            send_request(make_req(pbd_pkg::FUNC_START, '0));
            repeat (PHASE_ITEMS) begin
                send_request(random_request());
            end
        end
    endtask

    initial begin : out_stall_gen
        int hold_left;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (hold_left = LONG_HOLD_CYCLES - 1; hold_left > 0; hold_left--) begin
                    @(negedge i_clk);
                end
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                for (hold_left = $urandom_range(0, 3); hold_left > 0; hold_left--) begin
                    @(negedge i_clk);
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        pbd_pkg::t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.beat !== want.beat) begin
                    report_mismatch($sformatf("beat got %0d expected %0d",
                                              o_out_data.beat, want.beat));
                end
                if (o_out_data.beat_gap !== want.beat_gap) begin
                    report_mismatch($sformatf("beat_gap got %0d expected %0d",
                                              o_out_data.beat_gap, want.beat_gap));
                end
                if (o_out_data.bpm_valid !== want.bpm_valid) begin
                    report_mismatch($sformatf("bpm_valid got %0d expected %0d",
                                              o_out_data.bpm_valid, want.bpm_valid));
                end
                if (o_out_data.bpm !== want.bpm) begin
                    report_mismatch($sformatf("bpm got %0d expected %0d",
                                              o_out_data.bpm, want.bpm));
                end
                if (o_out_data.threshold !== want.threshold) begin
                    report_mismatch($sformatf("threshold got %0d expected %0d",
                                              o_out_data.threshold, want.threshold));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        detector_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_negative_threshold();
        test_beat_detection();
        test_output_hold();
        test_sender_pause();
        test_window_saturation();
        test_random_traffic();

        drain_outputs();
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
